[rtl/lup_matrix_inverse_macros.svh]
// ----------------------------------------------------------------------------
// LUP matrix inverse assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LUP_MATRIX_INVERSE_MACROS_SVH
`define LUP_MATRIX_INVERSE_MACROS_SVH

// same-cycle implication
`define LUPMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LUPMI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lupmi_pkg.sv]
// ----------------------------------------------------------------------------
// LUP matrix inverse package
// Data types, widths and helpers shared by the inverse datapath.
// ----------------------------------------------------------------------------
package lupmi_pkg;

  localparam int DATA_W = 32;
  localparam int PERM_W = 3;
  localparam int DIM_W  = 4;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_MAX = q_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam q_t Q_MIN = q_t'({1'b1, {(DATA_W-1){1'b0}}});

  typedef struct packed {
    logic start;
    q_t   a;
    q_t   b;
  } op_req_t;

  function automatic logic [DATA_W-1:0] mag_f(q_t v);
    logic [DATA_W-1:0] u;
    u = v;
    mag_f = v[DATA_W-1] ? (DATA_W'(0) - u) : u;
  endfunction

endpackage

[rtl/lupmi_elem_if.sv]
// ----------------------------------------------------------------------------
// Matrix element channel
// Carries one matrix element request with valid and ready.
// ----------------------------------------------------------------------------
interface lupmi_elem_if;
  import lupmi_pkg::*;

  logic valid;
  logic ready;
  q_t   elem_value;

  modport source(output valid, output elem_value, input ready);
  modport sink(input valid, input elem_value, output ready);
endinterface

[rtl/lupmi_inv_if.sv]
// ----------------------------------------------------------------------------
// Inverse result channel
// Carries one inverse element with its row permutation and status.
// ----------------------------------------------------------------------------
interface lupmi_inv_if;
  import lupmi_pkg::*;

  logic              valid;
  logic              ready;
  q_t                inv_value;
  logic [PERM_W-1:0] row_perm;
  logic              singular;
  logic              last;

  modport source(output valid, output inv_value, output row_perm, output singular,
                 output last, input ready);
  modport sink(input valid, input inv_value, input row_perm, input singular,
               input last, output ready);
endinterface

[rtl/lupmi_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the matrix dimension write request.
// ----------------------------------------------------------------------------
interface lupmi_cfg_if;
  import lupmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] matrix_dim;

  modport source(output valid, output matrix_dim, input ready);
  modport sink(input valid, input matrix_dim, output ready);
endinterface

[rtl/lup_matrix_inverse.sv]
// ----------------------------------------------------------------------------
// LUP matrix inverse
// Loads an n x n Q-format matrix, inverts it by LUP decomposition and
// streams the inverse with its row permutation.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle in row-major order into the matrix RAM.
// After the n*n-th element the block decomposes in place and solves each
// column of the inverse into the inverse RAM, then emits n*n results, each
// held until accepted, last flagged on the final one. The solve is bound by
// the shared multiply-subtract unit (about (n^3)/3 + n^2(n-1) operations)
// and the radix-4 divider (n(n-1)/2 + n^2 divisions). No element is taken
// from the end of the last element until the final result has been delivered.
// A zero pivot ends the decomposition early and every result then reports
// singular with value zero.
`include "lup_matrix_inverse_macros.svh"

module lup_matrix_inverse #(
  parameter int MAX_N     = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lupmi_elem_if.sink  elem_i,
  lupmi_inv_if.source inv_o,
  lupmi_cfg_if.sink   cfg_i
);
  import lupmi_pkg::*;

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW = $clog2(MAX_N + 1);
  localparam int AW = $clog2(MAX_N * MAX_N);
  localparam int SW = 6;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam logic [NW-1:0] N_RST = NW'((MAX_N < 8) ? MAX_N : 8);
  localparam q_t ONE_V = q_t'(64'sd1 <<< FRAC_BITS);

  localparam logic [SW-1:0] S_LOAD    = 6'd0;
  localparam logic [SW-1:0] S_INIT    = 6'd1;
  localparam logic [SW-1:0] S_PS_RD   = 6'd2;
  localparam logic [SW-1:0] S_PS_CMP  = 6'd3;
  localparam logic [SW-1:0] S_PS_END  = 6'd4;
  localparam logic [SW-1:0] S_PSW     = 6'd5;
  localparam logic [SW-1:0] S_RS_RD   = 6'd6;
  localparam logic [SW-1:0] S_RS_W1   = 6'd7;
  localparam logic [SW-1:0] S_RS_W2   = 6'd8;
  localparam logic [SW-1:0] S_U_RD    = 6'd9;
  localparam logic [SW-1:0] S_U_LD    = 6'd10;
  localparam logic [SW-1:0] S_L_RD    = 6'd11;
  localparam logic [SW-1:0] S_L_DIV   = 6'd12;
  localparam logic [SW-1:0] S_L_WAIT  = 6'd13;
  localparam logic [SW-1:0] S_E_RD    = 6'd14;
  localparam logic [SW-1:0] S_E_MAC   = 6'd15;
  localparam logic [SW-1:0] S_E_WAIT  = 6'd16;
  localparam logic [SW-1:0] S_F_RD    = 6'd17;
  localparam logic [SW-1:0] S_F_CHK   = 6'd18;
  localparam logic [SW-1:0] S_Y_INIT  = 6'd19;
  localparam logic [SW-1:0] S_Y_RD    = 6'd20;
  localparam logic [SW-1:0] S_Y_MAC   = 6'd21;
  localparam logic [SW-1:0] S_Y_WAIT  = 6'd22;
  localparam logic [SW-1:0] S_Y_WR    = 6'd23;
  localparam logic [SW-1:0] S_X_INIT  = 6'd24;
  localparam logic [SW-1:0] S_X_LD    = 6'd25;
  localparam logic [SW-1:0] S_X_RD    = 6'd26;
  localparam logic [SW-1:0] S_X_MAC   = 6'd27;
  localparam logic [SW-1:0] S_X_WAIT  = 6'd28;
  localparam logic [SW-1:0] S_X_DRD   = 6'd29;
  localparam logic [SW-1:0] S_X_DIV   = 6'd30;
  localparam logic [SW-1:0] S_X_DWAIT = 6'd31;
  localparam logic [SW-1:0] S_O_RD    = 6'd32;
  localparam logic [SW-1:0] S_O_LD    = 6'd33;
  localparam logic [SW-1:0] S_O_WAIT  = 6'd34;

  function automatic logic [AW-1:0] addr_f(logic [NW-1:0] r, logic [NW-1:0] c);
    addr_f = AW'(r[IW-1:0]) * AW'(MAX_N) + AW'(c[IW-1:0]);
  endfunction

  logic [SW-1:0]     state_q;
  logic [NW-1:0]     n_q;
  logic [NW-1:0]     n1;
  logic [NW-1:0]     n_cfg;
  logic [NW-1:0]     lr_q;
  logic [NW-1:0]     lc_q;
  logic [NW-1:0]     i_q;
  logic [NW-1:0]     j_q;
  logic [NW-1:0]     k_q;
  logic [NW-1:0]     c_q;
  logic [NW-1:0]     row_q;
  logic [DATA_W-1:0] best_q;
  logic              sing_q;
  q_t                u_q;
  q_t                l_q;
  q_t                acc_q;
  logic [IW-1:0]     ptmp_q;
  logic [IW-1:0]     perm_q [MAX_N];
  logic [IW-1:0]     p_ra;
  logic [IW-1:0]     p_rd;

  q_t                mat_mem [DEPTH];
  q_t                inv_mem [DEPTH];
  q_t                rda_q;
  q_t                rdb_q;
  q_t                inv_rd_q;
  logic [AW-1:0]     ra_a;
  logic [AW-1:0]     ra_b;
  logic [AW-1:0]     ra_i;
  logic              mwe;
  logic [AW-1:0]     mwa;
  q_t                mwd;
  logic              iwe;
  logic [AW-1:0]     iwa;
  q_t                iwd;

  logic              ov_q;
  q_t                oval_q;
  logic [PERM_W-1:0] operm_q;
  logic              osing_q;
  logic              olast_q;

  op_req_t           div_req;
  op_req_t           mac_req;
  logic              div_done;
  q_t                div_q;
  logic              mac_valid;
  q_t                mac_res;
  logic              in_ready;

  assign n1       = n_q - NW'(1);
  assign in_ready = (state_q == S_LOAD);

  always_comb begin
    if (cfg_i.matrix_dim == '0) begin
      n_cfg = NW'(1);
    end else if (int'(cfg_i.matrix_dim) > MAX_N) begin
      n_cfg = NW'(MAX_N);
    end else begin
      n_cfg = NW'(cfg_i.matrix_dim);
    end
  end

  lupmi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_q)
  );

  lupmi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mac_req),
    .acc_i   (acc_q),
    .valid_o (mac_valid),
    .res_o   (mac_res)
  );

  always_comb begin
    div_req.start = (state_q == S_L_DIV) || (state_q == S_X_DIV);
    div_req.a     = (state_q == S_X_DIV) ? acc_q : rda_q;
    div_req.b     = (state_q == S_X_DIV) ? rda_q : u_q;
    mac_req.start = (state_q == S_E_MAC) || (state_q == S_Y_MAC) || (state_q == S_X_MAC);
    mac_req.a     = (state_q == S_E_MAC) ? rdb_q : rda_q;
    mac_req.b     = (state_q == S_E_MAC) ? l_q : inv_rd_q;
  end

  always_comb begin
    ra_a = addr_f(i_q, j_q);
    ra_b = addr_f(row_q, j_q);
    ra_i = addr_f(i_q, c_q);
    p_ra = (state_q == S_PSW) ? row_q[IW-1:0] : i_q[IW-1:0];
    unique case (state_q)
      S_PS_RD, S_L_RD: ra_a = addr_f(j_q, i_q);
      S_U_RD, S_X_DRD: ra_a = addr_f(i_q, i_q);
      S_F_RD:          ra_a = addr_f(n1, n1);
      S_E_RD: begin
        ra_a = addr_f(j_q, k_q);
        ra_b = addr_f(i_q, k_q);
      end
      S_Y_RD, S_X_RD:  ra_i = addr_f(j_q, c_q);
      default: ;
    endcase
  end

  assign p_rd = perm_q[p_ra];

  always_comb begin
    mwe = 1'b0;
    mwa = addr_f(lr_q, lc_q);
    mwd = elem_i.elem_value;
    iwe = 1'b0;
    iwa = addr_f(i_q, c_q);
    iwd = acc_q;
    unique case (state_q)
      S_LOAD:  mwe = elem_i.valid;
      S_RS_W1: begin
        mwe = 1'b1;
        mwa = addr_f(i_q, j_q);
        mwd = rdb_q;
      end
      S_RS_W2: begin
        mwe = 1'b1;
        mwa = addr_f(row_q, j_q);
        mwd = rda_q;
      end
      S_L_WAIT: begin
        mwe = div_done;
        mwa = addr_f(j_q, i_q);
        mwd = div_q;
      end
      S_E_WAIT: begin
        mwe = mac_valid;
        mwa = addr_f(j_q, k_q);
        mwd = mac_res;
      end
      S_Y_WR:    iwe = 1'b1;
      S_X_DWAIT: begin
        iwe = div_done;
        iwd = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mat_mem[mwa] <= mwd;
    end
    rda_q <= mat_mem[ra_a];
    rdb_q <= mat_mem[ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (iwe) begin
      inv_mem[iwa] <= iwd;
    end
    inv_rd_q <= inv_mem[ra_i];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      for (int p = 0; p < MAX_N; p++) begin
        perm_q[p] <= IW'(p);
      end
    end else if (state_q == S_PSW) begin
      perm_q[i_q[IW-1:0]]   <= p_rd;
      perm_q[row_q[IW-1:0]] <= ptmp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      n_q     <= N_RST;
      lr_q    <= '0;
      lc_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      c_q     <= '0;
      row_q   <= '0;
      best_q  <= '0;
      sing_q  <= 1'b0;
      ov_q    <= 1'b0;
      ptmp_q  <= '0;
      u_q     <= '0;
      l_q     <= '0;
      acc_q   <= '0;
      oval_q  <= '0;
      operm_q <= '0;
      osing_q <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        n_q  <= n_cfg;
        lr_q <= '0;
        lc_q <= '0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (elem_i.valid) begin
            if (lc_q == n1) begin
              lc_q <= '0;
              if (lr_q == n1) begin
                lr_q    <= '0;
                state_q <= S_INIT;
              end else begin
                lr_q <= lr_q + NW'(1);
              end
            end else begin
              lc_q <= lc_q + NW'(1);
            end
          end
        end
        S_INIT: begin
          sing_q <= 1'b0;
          i_q    <= '0;
          j_q    <= '0;
          row_q  <= '0;
          best_q <= '0;
          state_q <= (n_q == NW'(1)) ? S_F_RD : S_PS_RD;
        end
        S_PS_RD: state_q <= S_PS_CMP;
        S_PS_CMP: begin
          if (mag_f(rda_q) > best_q) begin
            best_q <= mag_f(rda_q);
            row_q  <= j_q;
          end
          if (j_q == n1) begin
            state_q <= S_PS_END;
          end else begin
            j_q     <= j_q + NW'(1);
            state_q <= S_PS_RD;
          end
        end
        S_PS_END: begin
          if (best_q == '0) begin
            sing_q  <= 1'b1;
            i_q     <= '0;
            c_q     <= '0;
            state_q <= S_O_RD;
          end else begin
            ptmp_q  <= p_rd;
            state_q <= S_PSW;
          end
        end
        S_PSW: begin
          j_q     <= '0;
          state_q <= (row_q == i_q) ? S_U_RD : S_RS_RD;
        end
        S_RS_RD: state_q <= S_RS_W1;
        S_RS_W1: state_q <= S_RS_W2;
        S_RS_W2: begin
          if (j_q == n1) begin
            state_q <= S_U_RD;
          end else begin
            j_q     <= j_q + NW'(1);
            state_q <= S_RS_RD;
          end
        end
        S_U_RD: state_q <= S_U_LD;
        S_U_LD: begin
          u_q     <= rda_q;
          j_q     <= i_q + NW'(1);
          state_q <= S_L_RD;
        end
        S_L_RD:  state_q <= S_L_DIV;
        S_L_DIV: state_q <= S_L_WAIT;
        S_L_WAIT: begin
          if (div_done) begin
            l_q     <= div_q;
            k_q     <= i_q + NW'(1);
            state_q <= S_E_RD;
          end
        end
        S_E_RD: state_q <= S_E_MAC;
        S_E_MAC: begin
          acc_q   <= rda_q;
          state_q <= S_E_WAIT;
        end
        S_E_WAIT: begin
          if (mac_valid) begin
            if (k_q == n1) begin
              if (j_q == n1) begin
                if ((i_q + NW'(2)) == n_q) begin
                  state_q <= S_F_RD;
                end else begin
                  i_q     <= i_q + NW'(1);
                  j_q     <= i_q + NW'(1);
                  row_q   <= i_q + NW'(1);
                  best_q  <= '0;
                  state_q <= S_PS_RD;
                end
              end else begin
                j_q     <= j_q + NW'(1);
                state_q <= S_L_RD;
              end
            end else begin
              k_q     <= k_q + NW'(1);
              state_q <= S_E_RD;
            end
          end
        end
        S_F_RD: state_q <= S_F_CHK;
        S_F_CHK: begin
          i_q <= '0;
          c_q <= '0;
          if (rda_q == '0) begin
            sing_q  <= 1'b1;
            state_q <= S_O_RD;
          end else begin
            state_q <= S_Y_INIT;
          end
        end
        S_Y_INIT: begin
          acc_q   <= (p_rd == c_q[IW-1:0]) ? ONE_V : '0;
          j_q     <= '0;
          state_q <= (i_q == '0) ? S_Y_WR : S_Y_RD;
        end
        S_Y_RD:  state_q <= S_Y_MAC;
        S_Y_MAC: state_q <= S_Y_WAIT;
        S_Y_WAIT: begin
          if (mac_valid) begin
            acc_q <= mac_res;
            if ((j_q + NW'(1)) == i_q) begin
              state_q <= S_Y_WR;
            end else begin
              j_q     <= j_q + NW'(1);
              state_q <= S_Y_RD;
            end
          end
        end
        S_Y_WR: begin
          if (i_q == n1) begin
            state_q <= S_X_INIT;
          end else begin
            i_q     <= i_q + NW'(1);
            state_q <= S_Y_INIT;
          end
        end
        S_X_INIT: state_q <= S_X_LD;
        S_X_LD: begin
          acc_q   <= inv_rd_q;
          j_q     <= n1;
          state_q <= (i_q == n1) ? S_X_DRD : S_X_RD;
        end
        S_X_RD:  state_q <= S_X_MAC;
        S_X_MAC: state_q <= S_X_WAIT;
        S_X_WAIT: begin
          if (mac_valid) begin
            acc_q <= mac_res;
            if ((j_q - NW'(1)) == i_q) begin
              state_q <= S_X_DRD;
            end else begin
              j_q     <= j_q - NW'(1);
              state_q <= S_X_RD;
            end
          end
        end
        S_X_DRD: state_q <= S_X_DIV;
        S_X_DIV: state_q <= S_X_DWAIT;
        S_X_DWAIT: begin
          if (div_done) begin
            if (i_q == '0) begin
              if (c_q == n1) begin
                c_q     <= '0;
                state_q <= S_O_RD;
              end else begin
                c_q     <= c_q + NW'(1);
                state_q <= S_Y_INIT;
              end
            end else begin
              i_q     <= i_q - NW'(1);
              state_q <= S_X_INIT;
            end
          end
        end
        S_O_RD: state_q <= S_O_LD;
        S_O_LD: begin
          ov_q    <= 1'b1;
          oval_q  <= sing_q ? q_t'(0) : inv_rd_q;
          operm_q <= PERM_W'(p_rd);
          osing_q <= sing_q;
          olast_q <= (i_q == n1) && (c_q == n1);
          state_q <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (inv_o.ready) begin
            ov_q <= 1'b0;
            if (c_q == n1) begin
              c_q <= '0;
              if (i_q == n1) begin
                i_q     <= '0;
                lr_q    <= '0;
                lc_q    <= '0;
                state_q <= S_LOAD;
              end else begin
                i_q     <= i_q + NW'(1);
                state_q <= S_O_RD;
              end
            end else begin
              c_q     <= c_q + NW'(1);
              state_q <= S_O_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign elem_i.ready    = in_ready;
  assign cfg_i.ready     = 1'b1;
  assign inv_o.valid     = ov_q;
  assign inv_o.inv_value = oval_q;
  assign inv_o.row_perm  = operm_q;
  assign inv_o.singular  = osing_q;
  assign inv_o.last      = olast_q;

  `LUPMI_ASSERT_IMP(a_out_excl_load, ov_q, !in_ready, "result pending while loading")
  `LUPMI_ASSERT_IMP(a_sing_zero, ov_q && osing_q, oval_q == '0, "singular result not zero")
  `LUPMI_ASSERT_IMP(a_mac_state, mac_valid,
                    state_q == S_E_WAIT || state_q == S_Y_WAIT || state_q == S_X_WAIT,
                    "multiply result outside a wait state")

endmodule

[rtl/lupmi_div.sv]
// ----------------------------------------------------------------------------
// Fixed-point divider
// Radix-4 restoring divider, rounded to nearest on magnitudes, saturated.
// ----------------------------------------------------------------------------
`include "lup_matrix_inverse_macros.svh"

module lupmi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lupmi_pkg::op_req_t req_i,
  output logic              done_o,
  output lupmi_pkg::q_t     quot_o
);
  import lupmi_pkg::*;

  localparam int DW   = DATA_W + FRAC_BITS;
  localparam int DWP  = DW + (DW % 2);
  localparam int NSTP = DWP / 2;
  localparam int CW   = $clog2(NSTP + 1);
  localparam int RW   = DATA_W + 1;
  localparam logic [CW-1:0]  CNT_LAST = CW'(NSTP - 1);
  localparam logic [DWP-1:0] LIM_NEG  = DWP'(64'h8000_0000);
  localparam logic [DWP-1:0] LIM_POS  = DWP'(64'h7FFF_FFFF);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [DWP-1:0]    dvd_q;
  logic [DWP-1:0]    quo_q;
  logic [RW-1:0]     rem_q;
  logic [DATA_W-1:0] dvs_q;
  logic              neg_q;
  logic              zero_q;
  logic [RW-1:0]     rem_d;
  logic [DWP-1:0]    quo_d;
  logic [DATA_W-1:0] ua;
  logic [DATA_W-1:0] ub;

  assign ua = mag_f(req_i.a);
  assign ub = mag_f(req_i.b);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int s = 0; s < 2; s++) begin
      rem_d = {rem_d[RW-2:0], dvd_q[DWP-1-s]};
      if (rem_d >= RW'(dvs_q)) begin
        rem_d = rem_d - RW'(dvs_q);
        quo_d = {quo_d[DWP-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[DWP-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= (DWP'(ua) << FRAC_BITS) + DWP'(ub >> 1);
      dvs_q  <= ub;
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
      zero_q <= (ub == '0);
    end else if (busy_q) begin
      dvd_q <= dvd_q << 2;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = (quo_q > LIM_NEG) ? Q_MIN : q_t'(DATA_W'(0) - quo_q[DATA_W-1:0]);
    end else begin
      quot_o = (quo_q > LIM_POS) ? Q_MAX : q_t'(quo_q[DATA_W-1:0]);
    end
  end

  assign done_o = done_q;

  `LUPMI_ASSERT_IMP(a_div_start_idle, req_i.start, !busy_q, "divider restarted while busy")
  `LUPMI_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while busy")
  `LUPMI_ASSERT_NXT(a_div_finish, busy_q && !req_i.start && cnt_q == CNT_LAST, done_q,
                    "divider missed its done pulse")

endmodule

[rtl/lupmi_mac.sv]
// ----------------------------------------------------------------------------
// Fixed-point multiply-subtract
// Registered product, rounding and saturation, then saturated subtract.
// ----------------------------------------------------------------------------
module lupmi_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lupmi_pkg::op_req_t req_i,
  input  lupmi_pkg::q_t      acc_i,
  output logic               valid_o,
  output lupmi_pkg::q_t      res_o
);
  import lupmi_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam logic signed [PW-1:0] HALF   = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] P_MAX  = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] P_MIN  = -PW'(64'sd2147483648);

  logic                   v1_q;
  logic                   v2_q;
  logic signed [PW-1:0]   prod_q;
  q_t                     mul_q;
  logic signed [PW-1:0]   rnd;
  logic signed [PW-1:0]   shf;
  q_t                     mul_d;
  logic signed [DATA_W:0] diff;

  always_comb begin
    rnd = prod_q + HALF;
    shf = rnd >>> FRAC_BITS;
    if (shf > P_MAX) begin
      mul_d = Q_MAX;
    end else if (shf < P_MIN) begin
      mul_d = Q_MIN;
    end else begin
      mul_d = q_t'(shf[DATA_W-1:0]);
    end
  end

  always_comb begin
    diff = {acc_i[DATA_W-1], acc_i} - {mul_q[DATA_W-1], mul_q};
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      res_o = diff[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      res_o = q_t'(diff[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
    mul_q  <= mul_d;
  end

  assign valid_o = v2_q;

endmodule
